### rtl/tbpr_pkg.sv
package tbpr_pkg;

  localparam int VRAM_BYTES   = 8192;
  localparam int VRAM_WORDS   = VRAM_BYTES / 2;
  localparam int VRAM_AW      = $clog2(VRAM_BYTES);
  localparam int VRAM_WORD_AW = $clog2(VRAM_WORDS);
  localparam int SCREEN_WIDTH = 160;

  localparam logic [7:0]  HSCROLL_RESET          = 8'd0;
  localparam logic [7:0]  VSCROLL_RESET          = 8'd0;
  localparam logic        MAP_SELECT_RESET       = 1'b0;
  localparam logic        TILE_DATA_SELECT_RESET = 1'b1;
  localparam logic [31:0] SHADE_TABLE_RESET      = 32'hFF4A5A00;

  // Both tile maps live in the top 2 KiB of video memory (offsets 0x1800 and 0x1C00).
  localparam logic [1:0] MAP_REGION = 2'b11;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    REG_HSCROLL          = 3'd0,
    REG_VSCROLL          = 3'd1,
    REG_MAP_SELECT       = 3'd2,
    REG_TILE_DATA_SELECT = 3'd3,
    REG_SHADE_TABLE      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic               opcode;
    logic [VRAM_AW-1:0] vram_address;
    logic [7:0]         write_data;
    logic [7:0]         line;
    logic [7:0]         column;
  } in_item_t;

  typedef struct packed {
    logic [1:0] colour_index;
    logic [7:0] shade;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic [7:0]  hscroll;
    logic [7:0]  vscroll;
    logic        map_select;
    logic        tile_data_select;
    logic [31:0] shade_table;
  } cfg_t;

endpackage

### rtl/tbpr_stream_if.sv
interface tbpr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/tbpr_cfg_regs.sv
module tbpr_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  tbpr_stream_if.sink         cfg_ch,
  output tbpr_pkg::cfg_t      cfg
);

  tbpr_pkg::cfg_t cfg_r;
  tbpr_pkg::cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        tbpr_pkg::REG_HSCROLL:          cfg_nxt.hscroll          = cfg_ch.data.value[7:0];
        tbpr_pkg::REG_VSCROLL:          cfg_nxt.vscroll          = cfg_ch.data.value[7:0];
        tbpr_pkg::REG_MAP_SELECT:       cfg_nxt.map_select       = cfg_ch.data.value[0];
        tbpr_pkg::REG_TILE_DATA_SELECT: cfg_nxt.tile_data_select = cfg_ch.data.value[0];
        tbpr_pkg::REG_SHADE_TABLE:      cfg_nxt.shade_table      = cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hscroll          <= tbpr_pkg::HSCROLL_RESET;
      cfg_r.vscroll          <= tbpr_pkg::VSCROLL_RESET;
      cfg_r.map_select       <= tbpr_pkg::MAP_SELECT_RESET;
      cfg_r.tile_data_select <= tbpr_pkg::TILE_DATA_SELECT_RESET;
      cfg_r.shade_table      <= tbpr_pkg::SHADE_TABLE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/tbpr_vram.sv
module tbpr_vram (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                we,
  input  logic [tbpr_pkg::VRAM_AW-1:0]        wr_addr,
  input  logic [7:0]                          wr_data,
  input  logic [tbpr_pkg::VRAM_WORD_AW-1:0]   map_addr,
  input  logic [tbpr_pkg::VRAM_WORD_AW-1:0]   tile_addr,
  output logic [15:0]                         map_word,
  output logic [15:0]                         tile_word
);

  // Even bytes sit in the low bank and odd bytes in the high bank, so one word read
  // returns both bit planes of a tile row.
  logic [7:0] bank_lo [tbpr_pkg::VRAM_WORDS];
  logic [7:0] bank_hi [tbpr_pkg::VRAM_WORDS];

  logic [7:0] map_lo_r, map_hi_r, tile_lo_r, tile_hi_r;

  logic [tbpr_pkg::VRAM_WORD_AW-1:0] wr_word;

  assign wr_word = wr_addr[tbpr_pkg::VRAM_AW-1:1];

  // A read in the same cycle as a write to that word returns the old byte.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we && !wr_addr[0]) begin
        bank_lo[wr_word] <= wr_data;
      end
      map_lo_r  <= bank_lo[map_addr];
      tile_lo_r <= bank_lo[tile_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (we && wr_addr[0]) begin
        bank_hi[wr_word] <= wr_data;
      end
      map_hi_r  <= bank_hi[map_addr];
      tile_hi_r <= bank_hi[tile_addr];
    end
  end

  assign map_word  = {map_hi_r, map_lo_r};
  assign tile_word = {tile_hi_r, tile_lo_r};

endmodule

### rtl/tbpr_pixel.sv
module tbpr_pixel (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld,
  input  logic [2:0]   fine_x,
  input  logic [15:0]  tile_word,
  input  logic [31:0]  shade_table,
  output logic         advance,
  tbpr_stream_if.source out_ch
);

  logic                 out_valid_r;
  tbpr_pkg::out_item_t  out_data_r;
  tbpr_pkg::out_item_t  out_data_nxt;
  logic [2:0]           bit_sel;

  // Pixel 0 of a row is the most significant bit of each plane.
  assign bit_sel = ~fine_x;

  always_comb begin
    out_data_nxt.colour_index = {tile_word[8 + 32'(bit_sel)], tile_word[32'(bit_sel)]};
    out_data_nxt.shade        = shade_table[8 * 32'(out_data_nxt.colour_index) +: 8];
  end

  assign advance = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

### rtl/tile_background_pixel_renderer_unit.sv
// Channel  Role    Payload                                           Transfer
// in_ch    sink    opcode, vram_address, write_data, line, column    valid && ready
// out_ch   source  colour_index, shade                               valid && ready
// cfg_ch   sink    index, value                                      valid && ready
//
// One item is taken per cycle while out_ch does not stall; a rendered pixel passes s1, s2, s3 and the output register.
// The depth is set by the two dependent memory reads: the tile map, then the bit planes.
// Writes and off-screen renders flow through and give no result.
// rst_n is synchronous; it empties the pipeline and restores the registers.
// Video memory is not cleared. A stall on out_ch freezes every stage at once.
module tile_background_pixel_renderer_unit #(
  parameter int SCREEN_WIDTH = tbpr_pkg::SCREEN_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  tbpr_stream_if.sink   in_ch,
  tbpr_stream_if.source out_ch,
  tbpr_stream_if.sink   cfg_ch
);

  tbpr_pkg::cfg_t cfg;
  logic           adv;
  logic           accept;

  logic       s1_wr_r, s1_rd_r;
  logic [tbpr_pkg::VRAM_AW-1:0] s1_addr_r;
  logic [7:0] s1_data_r, s1_px_r, s1_py_r;

  logic       s2_vld_r, s2_sel_r;
  logic [2:0] s2_fine_x_r, s2_fine_y_r;

  logic       s3_vld_r;
  logic [2:0] s3_fine_x_r;

  logic [tbpr_pkg::VRAM_WORD_AW-1:0] map_addr, tile_addr;
  logic [15:0] map_word, tile_word;
  logic [7:0]  tile_num;
  logic        on_screen;

  tbpr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign on_screen   = {1'b0, in_ch.data.column} < 9'(SCREEN_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_wr_r  <= 1'b0;
      s1_rd_r  <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_wr_r  <= accept && (in_ch.data.opcode == tbpr_pkg::OP_WRITE);
      s1_rd_r  <= accept && (in_ch.data.opcode == tbpr_pkg::OP_RENDER) && on_screen;
      s2_vld_r <= s1_rd_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r   <= in_ch.data.vram_address;
      s1_data_r   <= in_ch.data.write_data;
      s1_px_r     <= in_ch.data.column + cfg.hscroll;
      s1_py_r     <= in_ch.data.line + cfg.vscroll;
      s2_sel_r    <= s1_px_r[3];
      s2_fine_x_r <= s1_px_r[2:0];
      s2_fine_y_r <= s1_py_r[2:0];
      s3_fine_x_r <= s2_fine_x_r;
    end
  end

  // Map entry at base + 32 * (py / 8) + px / 8, as a word address plus byte select.
  assign map_addr = {tbpr_pkg::MAP_REGION, cfg.map_select, s1_py_r[7:3], s1_px_r[7:4]};

  // Signed addressing puts tiles 0..127 at offset 0x1000 and tiles 128..255 at 0x0800, which
  // differs from unsigned addressing only in bit 12 of the byte offset.
  assign tile_num  = s2_sel_r ? map_word[15:8] : map_word[7:0];
  assign tile_addr = {!cfg.tile_data_select && !tile_num[7], tile_num, s2_fine_y_r};

  tbpr_vram u_vram (
    .clk       (clk),
    .en        (adv),
    .we        (s1_wr_r),
    .wr_addr   (s1_addr_r),
    .wr_data   (s1_data_r),
    .map_addr  (map_addr),
    .tile_addr (tile_addr),
    .map_word  (map_word),
    .tile_word (tile_word)
  );

  tbpr_pixel u_pixel (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld         (s3_vld_r),
    .fine_x      (s3_fine_x_r),
    .tile_word   (tile_word),
    .shade_table (cfg.shade_table),
    .advance     (adv),
    .out_ch      (out_ch)
  );

endmodule

### dv/tb_top.sv
module tb_top;
  import tbpr_pkg::*;

  localparam int PIPE_LATENCY      = 4;
  localparam int SETTLE_CYCLES     = 3 * PIPE_LATENCY;
  localparam int STALL_LIMIT       = 2000;
  localparam int ITEMS_PER_SETTING = 120;

  logic clk = 1'b0;
  logic rst_n;

  tbpr_stream_if #(.payload_t(in_item_t))   in_ch ();
  tbpr_stream_if #(.payload_t(out_item_t))  out_ch ();
  tbpr_stream_if #(.payload_t(cfg_write_t)) cfg_ch ();

  tile_background_pixel_renderer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  cfg_t       shadow_cfg;
  logic [7:0] vram_mirror [VRAM_BYTES];
  bit         vram_written [VRAM_BYTES];
  out_item_t  pixel_queue [$];
  int         mismatch_count = 0;
  int         burst_left = 0;

  function automatic cfg_t pack_settings(logic [7:0] sx, logic [7:0] sy, logic map_sel,
                                         logic data_sel, logic [31:0] shades);
    cfg_t s;
    s.hscroll          = sx;
    s.vscroll          = sy;
    s.map_select       = map_sel;
    s.tile_data_select = data_sel;
    s.shade_table      = shades;
    return s;
  endfunction

  function automatic logic [VRAM_AW-1:0] map_entry_addr(logic [7:0] line, logic [7:0] column);
    logic [7:0] px;
    logic [7:0] py;
    px = column + shadow_cfg.hscroll;
    py = line + shadow_cfg.vscroll;
    return {MAP_REGION, shadow_cfg.map_select, py[7:3], px[7:3]};
  endfunction

  function automatic logic [VRAM_AW-1:0] tile_row_addr(logic [7:0] tile, logic [7:0] line);
    logic [7:0] py;
    int         base;
    py = line + shadow_cfg.vscroll;
    // In signed mode the tile number counts from offset 0x1000 in both directions.
    if (shadow_cfg.tile_data_select) begin
      base = int'(tile) * 16;
    end else begin
      base = 'h1000 + int'($signed(tile)) * 16;
    end
    return VRAM_AW'(base + int'(py[2:0]) * 2);
  endfunction

  function automatic out_item_t render_pixel(logic [7:0] line, logic [7:0] column);
    logic [VRAM_AW-1:0] row_addr;
    logic [7:0]         px;
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [2:0]         bit_sel;
    out_item_t          pixel;
    px       = column + shadow_cfg.hscroll;
    row_addr = tile_row_addr(vram_mirror[map_entry_addr(line, column)], line);
    lo       = vram_mirror[row_addr];
    hi       = vram_mirror[row_addr + 1'b1];
    bit_sel  = 3'd7 - px[2:0];
    pixel.colour_index = {hi[bit_sel], lo[bit_sel]};
    pixel.shade        = shadow_cfg.shade_table[8 * pixel.colour_index +: 8];
    return pixel;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer with valid
  // still high, so a back-to-back item never toggles valid within one step.
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(40, 160);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 20);
        gap        = $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    if (item.opcode == OP_WRITE) begin
      vram_mirror[item.vram_address]  = item.write_data;
      vram_written[item.vram_address] = 1'b1;
    end else if (item.column < SCREEN_WIDTH) begin
      pixel_queue.push_back(render_pixel(item.line, item.column));
    end
    @(negedge clk);
  endtask

  task automatic write_byte(input logic [VRAM_AW-1:0] addr, input logic [7:0] data);
    in_item_t item;
    item.opcode       = OP_WRITE;
    item.vram_address = addr;
    item.write_data   = data;
    item.line         = 8'($urandom);
    item.column       = 8'($urandom);
    send_item(item);
  endtask

  task automatic render_at(input logic [7:0] line, input logic [7:0] column);
    logic [VRAM_AW-1:0] entry;
    logic [VRAM_AW-1:0] row_addr;
    in_item_t           item;
    if (column < SCREEN_WIDTH) begin
      // Fill every byte this pixel fetches so that no read lands on unwritten memory.
      entry = map_entry_addr(line, column);
      if (!vram_written[entry]) write_byte(entry, 8'($urandom));
      row_addr = tile_row_addr(vram_mirror[entry], line);
      if (!vram_written[row_addr]) write_byte(row_addr, 8'($urandom));
      if (!vram_written[row_addr + 1'b1]) write_byte(row_addr + 1'b1, 8'($urandom));
    end
    item.opcode       = OP_RENDER;
    item.vram_address = VRAM_AW'($urandom);
    item.write_data   = 8'($urandom);
    item.line         = line;
    item.column       = column;
    send_item(item);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pixel_queue.size() != 0) @(negedge clk);
    // Writes and off-screen renders may still be in flight without a pixel to show for it.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t index, input logic [31:0] value);
    cfg_write_t w;
    w.index = index;
    w.value = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      REG_HSCROLL:          shadow_cfg.hscroll          = value[7:0];
      REG_VSCROLL:          shadow_cfg.vscroll          = value[7:0];
      REG_MAP_SELECT:       shadow_cfg.map_select       = value[0];
      REG_TILE_DATA_SELECT: shadow_cfg.tile_data_select = value[0];
      REG_SHADE_TABLE:      shadow_cfg.shade_table      = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    wait_drained();
    write_reg(REG_HSCROLL, {24'd0, s.hscroll});
    write_reg(REG_VSCROLL, {24'd0, s.vscroll});
    write_reg(REG_MAP_SELECT, {31'd0, s.map_select});
    write_reg(REG_TILE_DATA_SELECT, {31'd0, s.tile_data_select});
    write_reg(REG_SHADE_TABLE, s.shade_table);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    // Tile 0, row 0: low plane all ones and high plane clear, so the row shows colour 1.
    write_byte(map_entry_addr(8'd0, 8'd0), 8'h00);
    write_byte(13'h0000, 8'hFF);
    write_byte(13'h0001, 8'h00);
    render_at(8'd0, 8'd0);
    render_at(8'd143, 8'd159);
    render_at(8'd255, 8'd7);
    render_at(8'd200, 8'd160);
    render_at(8'd0, 8'd255);
  endtask

  task automatic test_signed_tiles();
    apply_settings(pack_settings(8'hFF, 8'hFF, 1'b1, 1'b0, 32'hC0804000));
    // With both scrolls at 255 the first pixel wraps to the last entry of the second map.
    write_byte(13'h1FFF, 8'hFF);
    write_byte(map_entry_addr(8'd9, 8'd9), 8'h80);
    write_byte(map_entry_addr(8'd17, 8'd17), 8'h7F);
    write_byte(map_entry_addr(8'd30, 8'd40), 8'h00);
    render_at(8'd0, 8'd0);
    render_at(8'd9, 8'd9);
    render_at(8'd17, 8'd17);
    render_at(8'd30, 8'd40);
    render_at(8'd250, 8'd100);
  endtask

  task automatic random_item();
    int pick;
    if ($urandom_range(0, 299) == 0) wait_drained();
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      render_at(8'($urandom), 8'($urandom_range(0, SCREEN_WIDTH - 1)));
    end else if (pick < 80) begin
      write_byte(VRAM_AW'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      write_byte({MAP_REGION, 11'($urandom)}, 8'($urandom));
    end else begin
      render_at(8'($urandom), 8'($urandom_range(SCREEN_WIDTH, 255)));
    end
  endtask

  task automatic test_random_traffic();
    cfg_t plan [6];
    plan[0] = pack_settings(8'h00, 8'h00, 1'b0, 1'b1, SHADE_TABLE_RESET);
    plan[1] = pack_settings(8'hFF, 8'hFF, 1'b1, 1'b0, 32'hFFFFFFFF);
    plan[2] = pack_settings(8'($urandom), 8'($urandom), 1'b0, 1'b0, 32'h00000000);
    plan[3] = pack_settings(8'($urandom), 8'($urandom), 1'b1, 1'b1, $urandom);
    plan[4] = pack_settings(8'hFF, 8'h00, 1'b0, 1'b1, $urandom);
    plan[5] = pack_settings(8'h00, 8'hFF, 1'b1, 1'b0, $urandom);
    foreach (plan[i]) begin
      apply_settings(plan[i]);
      repeat (ITEMS_PER_SETTING) random_item();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    shadow_cfg   = pack_settings(HSCROLL_RESET, VSCROLL_RESET, MAP_SELECT_RESET,
                                 TILE_DATA_SELECT_RESET, SHADE_TABLE_RESET);
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_signed_tiles();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // The receiver replays a random 16-bit ready pattern, often a fully open one.
  initial begin : receiver_stall
    logic [15:0] stall_pattern;
    int          stall_pos;
    out_ch.ready  = 1'b0;
    stall_pattern = '1;
    stall_pos     = 0;
    forever begin
      @(negedge clk);
      if (stall_pos == 0) begin
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      out_ch.ready <= stall_pattern[stall_pos];
      stall_pos = (stall_pos + 1) % 16;
    end
  end

  always @(posedge clk) begin
    out_item_t expected;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel: colour_index %0d, shade 0x%02h",
               out_ch.data.colour_index, out_ch.data.shade);
        mismatch_count++;
      end else begin
        expected = pixel_queue.pop_front();
        if (out_ch.data.colour_index !== expected.colour_index) begin
          $error("colour_index mismatch: expected %0d, actual %0d",
                 expected.colour_index, out_ch.data.colour_index);
          mismatch_count++;
        end
        if (out_ch.data.shade !== expected.shade) begin
          $error("shade mismatch: expected 0x%02h, actual 0x%02h",
                 expected.shade, out_ch.data.shade);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
